// ===== design/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: payload structs, controller/datapath command
// and status types, round constants and the round and schedule functions.
// Depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] message_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic [1:0] {
    BSRC_MSG  = 2'd0,
    BSRC_PAD  = 2'd1,
    BSRC_ZERO = 2'd2,
    BSRC_LEN  = 2'd3
  } bsrc_t;

  typedef struct packed {
    logic       wr_byte;
    bsrc_t      bsrc;
    logic       count_byte;
    logic       blk_start;
    logic       round_step;
    logic       chain_add;
    logic       msg_reset;
    logic [5:0] round_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_sts_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

  localparam logic [5:0] PAD_LIMIT = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== design/sha_datapath.sv =====
// Datapath: byte counter, 16-word schedule window loaded byte by byte, working
// variables and chaining words. Uses sha_pkg; driven by sha_ctrl.
`timescale 1ns / 1ps
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        msg_byte,
  input  sha_pkg::dp_cmd_t  cmd,
  input  logic [2:0]        rd_idx,
  output logic [31:0]       rd_word,
  output sha_pkg::dp_sts_t  sts
);

  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] total_r, total_nxt;
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [7:0]  wbyte;
  logic [63:0] bits;
  logic [31:0] wt, wnew, t1, t2;
  logic [31:0] hsel [8];

  assign bits = {total_r[60:0], 3'b000};

  always_comb begin
    case (cmd.bsrc)
      sha_pkg::BSRC_MSG:  wbyte = msg_byte;
      sha_pkg::BSRC_PAD:  wbyte = sha_pkg::PAD_BYTE;
      sha_pkg::BSRC_ZERO: wbyte = 8'h00;
      sha_pkg::BSRC_LEN:  wbyte = bits[8 * (7 - fill_r[2:0]) +: 8];
      default:            wbyte = 8'h00;
    endcase
  end

  always_comb begin
    fill_nxt  = fill_r;
    total_nxt = total_r;
    if (cmd.wr_byte) fill_nxt = fill_r + 6'd1;
    if (cmd.count_byte) total_nxt = total_r + 64'd1;
    if (cmd.msg_reset) begin
      fill_nxt  = '0;
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  assign wt   = w_r[0];
  assign wnew = sha_pkg::sig1(w_r[14]) + w_r[9] + sha_pkg::sig0(w_r[1]) + w_r[0];
  assign t1   = v_r[7] + sha_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + sha_pkg::ROUND_K[cmd.round_idx] + wt;
  assign t2   = sha_pkg::bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^
                (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], wbyte};
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hsel[i] = cmd.msg_reset ? sha_pkg::INIT_H[i] : h_r[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_step) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::INIT_H[i];
    end else if (cmd.chain_add) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end else if (cmd.msg_reset) begin
      for (int i = 0; i < 8; i++) h_r[i] <= hsel[i];
    end
  end

  assign rd_word  = h_r[rd_idx];
  assign sts.fill = fill_r;

endmodule

// ===== design/sha_ctrl.sv =====
// Controller: input and output handshakes, padding sequence, round counter
// and digest readout. Uses sha_pkg; commands sha_datapath.
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_idx,
  output sha_pkg::dp_cmd_t  cmd,
  input  sha_pkg::dp_sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       fin_r, fin_nxt;
  logic       padlen_r, padlen_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_idx   = idx_r;

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    padlen_nxt = padlen_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    cmd.bsrc   = sha_pkg::BSRC_MSG;
    cmd.round_idx = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_byte = 1'b1;
          if (in_func == sha_pkg::FUNC_ABSORB) begin
            cmd.count_byte = 1'b1;
            fin_nxt = 1'b0;
            if (sts.fill == 6'd63) state_nxt = S_LOAD;
          end else begin
            cmd.bsrc   = sha_pkg::BSRC_PAD;
            fin_nxt    = 1'b1;
            padlen_nxt = (sts.fill < sha_pkg::PAD_LIMIT);
            state_nxt  = (sts.fill == 6'd63) ? S_LOAD : S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.wr_byte = 1'b1;
        if (padlen_r && sts.fill >= sha_pkg::PAD_LIMIT) cmd.bsrc = sha_pkg::BSRC_LEN;
        else cmd.bsrc = sha_pkg::BSRC_ZERO;
        if (sts.fill == 6'd63) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.blk_start  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (padlen_r) begin
          idx_nxt    = '0;
          ovalid_nxt = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          padlen_nxt = 1'b1;
          state_nxt  = S_PAD;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            ovalid_nxt    = 1'b0;
            cmd.msg_reset = 1'b1;
            fin_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      padlen_r <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      fin_r    <= fin_nxt;
      padlen_r <= padlen_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== design/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: joins sha_ctrl and sha_datapath.
// Uses sha_pkg.
//
// An absorb transfer that fills a block is followed by the working-variable load,
// 64 rounds of one round per cycle and the chaining add before the next is taken.
// A finish transfer writes the padding one byte per cycle up to the block end,
// compresses once or twice (twice when 56 or more bytes are held), then offers
// the eight digest words, one per out transfer. No new item is taken until the
// last word has transferred.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sha_pkg::out_item_t  out_data
);

  sha_pkg::dp_cmd_t cmd;
  sha_pkg::dp_sts_t sts;
  logic [2:0]       idx;
  logic [31:0]      word;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_data.func), .out_ready(out_ready), .out_valid(out_valid),
    .out_idx(idx), .cmd(cmd), .sts(sts)
  );

  sha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .msg_byte(in_data.message_byte), .cmd(cmd),
    .rd_idx(idx), .rd_word(word), .sts(sts)
  );

  assign out_data.digest_word = word;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while digest pending");

  a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && idx != 3'd7) |=> (out_valid && idx == $past(idx) + 3'd1))
    else $error("digest index did not advance");

  a_last_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && idx == 3'd7) |=> (!out_valid && in_ready))
    else $error("block not idle after last word");

endmodule

// ===== dv/tb_sha256_stream_hasher.sv =====
// Testbench for sha256_stream_hasher: drives absorb and finish transfers, predicts
// each digest word with an independent SHA-256 model and checks every out transfer.
// Depends on sha_pkg and the RTL of sha256_stream_hasher.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;

  localparam int CYCLE_LIMIT = 400000;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sha_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sha_pkg::out_item_t out_data;

  sha256_stream_hasher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  sha_pkg::in_item_t  pending_items[$];
  sha_pkg::out_item_t digest_queue[$];
  logic [31:0] hash_h[8];
  logic [7:0]  blk_buf[64];
  int          blk_fill;
  logic [63:0] msg_bytes;
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int words_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic hash_item(sha_pkg::in_item_t it);
    logic [63:0] bitlen;
    sha_pkg::out_item_t r;
    if (it.func == sha_pkg::FUNC_ABSORB) begin
      blk_buf[blk_fill] = it.message_byte;
      blk_fill++;
      msg_bytes++;
      if (blk_fill == 64) begin
        compress_blk();
        blk_fill = 0;
      end
    end else begin
      bitlen = msg_bytes << 3;
      blk_buf[blk_fill] = 8'h80;
      blk_fill++;
      if (blk_fill > 56) begin
        while (blk_fill < 64) begin blk_buf[blk_fill] = 8'h00; blk_fill++; end
        compress_blk();
        blk_fill = 0;
      end
      while (blk_fill < 56) begin blk_buf[blk_fill] = 8'h00; blk_fill++; end
      for (int k = 0; k < 8; k++) blk_buf[56+k] = bitlen[63-8*k -: 8];
      compress_blk();
      for (int k = 0; k < 8; k++) begin
        r.digest_word = hash_h[k];
        r.word_index = 3'(k);
        r.last_word = (k == 7);
        digest_queue.push_back(r);
      end
      hash_h = IV_TAB;
      blk_fill = 0;
      msg_bytes = '0;
    end
  endtask

  task automatic add_msg(int len, bit fixed, logic [7:0] val);
    sha_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.func = sha_pkg::FUNC_ABSORB;
      it.message_byte = fixed ? val : 8'($urandom);
      pending_items.push_back(it);
    end
    it.func = sha_pkg::FUNC_FINISH;
    it.message_byte = 8'($urandom);
    pending_items.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        hash_item(in_data);
        sent <= sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_seen <= words_seen + 1;
      if (digest_queue.size() == 0) begin
        $error("unexpected digest word %h", out_data.digest_word);
        errors++;
      end else begin
        sha_pkg::out_item_t e;
        e = digest_queue.pop_front();
        if (out_data.digest_word !== e.digest_word) begin
          $error("digest_word exp %h got %h", e.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_index !== e.word_index) begin
          $error("word_index exp %0d got %0d", e.word_index, out_data.word_index);
          errors++;
        end
        if (out_data.last_word !== e.last_word) begin
          $error("last_word exp %0d got %0d", e.last_word, out_data.last_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic run_phase(int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    while (pending_items.size() > 0 || in_valid || digest_queue.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    hash_h = IV_TAB;
    blk_fill = 0;
    msg_bytes = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // full block then 55 held bytes: single padding block at the boundary
    add_msg(119, 0, 8'h00);
    run_phase(0, 0);
    // 56 held bytes: padding spills into a second block
    add_msg(56, 0, 8'h00);
    run_phase(62, 0);
    add_msg(0, 1, 8'h00);
    add_msg(1, 1, 8'hff);
    run_phase(0, 62);
    add_msg(int'($urandom_range(0, 3)), 0, 8'h00);
    add_msg(int'($urandom_range(0, 3)), 0, 8'h00);
    run_phase(23, 23);
    repeat (200) @(posedge clk);
    $display("sent %0d input transfers, checked %0d digest words", sent, words_seen);
    $display("covered empty, short, padding-boundary and multi-block messages");
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
